>>> sv/maze_backtracker_generator_assert.svh
// Assertion macros for the maze generator
`ifndef MAZE_BACKTRACKER_GENERATOR_ASSERT_SVH
`define MAZE_BACKTRACKER_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset
`define MBG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("mbg assertion failed");
// Check that a condition is followed by another in the next cycle
`define MBG_ASSERT_NEXT(lbl, clk, rstn, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) \
        else $error("mbg sequence assertion failed");
`else
`define MBG_ASSERT(lbl, clk, rstn, prop)
`define MBG_ASSERT_NEXT(lbl, clk, rstn, cond, nxt)
`endif

`endif

>>> sv/mbg_pkg.sv
package mbg_pkg;

    // Default sizes
    localparam int DEF_MAX_WIDTH   = 64;
    localparam int DEF_MAX_HEIGHT  = 64;
    localparam int DEF_STACK_DEPTH = 1024;

    // Configuration register indexes
    localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [2:0] REG_START_X     = 3'd2;
    localparam logic [2:0] REG_START_Y     = 3'd3;
    localparam logic [2:0] REG_END_X       = 3'd4;
    localparam logic [2:0] REG_END_Y       = 3'd5;
    localparam logic [2:0] REG_DIFFICULTY  = 3'd6;

    // Request modes
    localparam logic [1:0] MODE_BEGIN  = 2'd0;
    localparam logic [1:0] MODE_WALK   = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    // Difficulty codes
    localparam logic [1:0] DIFF_EASY   = 2'd0;
    localparam logic [1:0] DIFF_MEDIUM = 2'd1;

    // Raster pass residue constants: (31x + 17y) mod divisor
    localparam int COEF_X   = 31;
    localparam int COEF_Y   = 17;
    localparam int EASY_DIV = 3;
    localparam int MED_DIV  = 7;
    localparam logic [2:0] EASY_DIV_C = 3'(EASY_DIV);
    localparam logic [2:0] MED_DIV_C  = 3'(MED_DIV);
    localparam logic [2:0] EASY_XSTEP = 3'(COEF_X % EASY_DIV);
    localparam logic [2:0] EASY_YSTEP = 3'(COEF_Y % EASY_DIV);
    localparam logic [2:0] MED_XSTEP  = 3'(COEF_X % MED_DIV);
    localparam logic [2:0] MED_YSTEP  = 3'(COEF_Y % MED_DIV);

    typedef enum logic [1:0] {
        DIR_PX = 2'd0,
        DIR_MX = 2'd1,
        DIR_PY = 2'd2,
        DIR_MY = 2'd3
    } dir_t;

    typedef enum logic [4:0] {
        ST_RST_CLR,
        ST_IDLE,
        ST_BEG_CLR,
        ST_BEG_SET,
        ST_TOP,
        ST_PROBE,
        ST_EVAL,
        ST_CARVE,
        ST_MID,
        ST_FIN_START,
        ST_FIN_END,
        ST_FIN_LEFT,
        ST_FIN_UP,
        ST_RAS_READ,
        ST_RAS_CHK,
        ST_RAS_PROBE,
        ST_RAS_EVAL,
        ST_READ,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] choice;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
    } in_t;

    typedef struct packed {
        logic wall;
        logic walk_done;
        logic out_of_range;
    } out_t;

    // Residue of a 16-bit value modulo 3 by folding base-4 digits
    function automatic logic [1:0] mod3(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[4]) + 3'(s[3:2]) + 3'(s[1:0]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

    // Add a step to a residue, one compare and subtract
    function automatic logic [2:0] res_add(input logic [2:0] r, input logic [2:0] a,
                                           input logic [2:0] d);
        logic [3:0] s;
        s = 4'(r) + 4'(a);
        if (s >= 4'(d)) begin
            s = s - 4'(d);
        end
        return s[2:0];
    endfunction

endpackage

>>> sv/maze_backtracker_generator.sv
// Maze generator by randomised depth-first backtracking over a wall map, a visited map and a
// cell stack, all in single-port-write RAMs with a registered read. One request is taken at a
// time; a small sequencer drives a shared neighbour-address unit and the map read port. After
// reset the maps are swept once, one cell a cycle, and no request is taken meanwhile. Begin
// sweeps the maps again before it sets the start cell; a walk step probes the four neighbours
// and then carves or pops, and skips the probes on an empty stack; a read outside the grid
// answers without a map read; finish opens the start and end cells and, for easy or medium,
// runs a raster pass over the grid with up to five map reads per cell. A result is held in an
// output register, and a stalled result holds off the next request.
module maze_backtracker_generator
    import mbg_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_t        s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_data,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_wdata
);

`include "maze_backtracker_generator_assert.svh"

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int CELLS = 1 << AW;
    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int CW    = $clog2(STACK_DEPTH + 1);

    // Configuration registers
    logic [6:0] grid_width_reg, grid_height_reg;
    logic [5:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [1:0] difficulty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= 7'd64;
            grid_height_reg <= 7'd64;
            start_x_reg     <= 6'd0;
            start_y_reg     <= 6'd0;
            end_x_reg       <= 6'd63;
            end_y_reg       <= 6'd63;
            difficulty_reg  <= 2'd2;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata;
                REG_START_X:     start_x_reg     <= cfg_wdata[5:0];
                REG_START_Y:     start_y_reg     <= cfg_wdata[5:0];
                REG_END_X:       end_x_reg       <= cfg_wdata[5:0];
                REG_END_Y:       end_y_reg       <= cfg_wdata[5:0];
                REG_DIFFICULTY:  difficulty_reg  <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Effective grid size and clamped start and end cells
    logic [XW:0]   ew;
    logic [YW:0]   eh;
    logic [XW-1:0] sx, ex;
    logic [YW-1:0] sy, ey;

    always_comb begin
        if (grid_width_reg == 7'd0) begin
            ew = (XW+1)'(1);
        end else if (int'(grid_width_reg) > MAX_WIDTH) begin
            ew = (XW+1)'(MAX_WIDTH);
        end else begin
            ew = (XW+1)'(grid_width_reg);
        end
        if (grid_height_reg == 7'd0) begin
            eh = (YW+1)'(1);
        end else if (int'(grid_height_reg) > MAX_HEIGHT) begin
            eh = (YW+1)'(MAX_HEIGHT);
        end else begin
            eh = (YW+1)'(grid_height_reg);
        end
        sx = (int'(start_x_reg) >= int'(ew)) ? XW'(ew - 1'b1) : XW'(start_x_reg);
        ex = (int'(end_x_reg) >= int'(ew)) ? XW'(ew - 1'b1) : XW'(end_x_reg);
        sy = (int'(start_y_reg) >= int'(eh)) ? YW'(eh - 1'b1) : YW'(start_y_reg);
        ey = (int'(end_y_reg) >= int'(eh)) ? YW'(eh - 1'b1) : YW'(end_y_reg);
    end

    // Sequencer state
    state_t         state_reg, state_next;
    logic [XW-1:0]  cx_reg, cx_next;
    logic [YW-1:0]  cy_reg, cy_next;
    dir_t           dir_reg, dir_next;
    logic [3:0]     mask_reg, mask_next;
    logic [2:0]     res_reg, res_next, rowres_reg, rowres_next;
    logic [CW-1:0]  sc_reg, sc_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic           ok_reg, ok_next;
    in_t            in_reg, in_next;
    logic           rwall_reg, rwall_next, roor_reg, roor_next;
    logic           m_valid_reg, m_valid_next;
    out_t           m_data_reg, m_data_next;

    // Map and stack ports
    logic            wall_we, vis_we, stk_we;
    logic [AW-1:0]   wall_waddr, vis_waddr, map_raddr;
    logic            wall_wdata, vis_wdata, wall_rdata, vis_rdata;
    logic [SAW-1:0]  stk_waddr, stk_raddr;
    logic [AW-1:0]   stk_wdata, stk_rdata;

    mbg_ram #(.DATA_W(1), .DEPTH(CELLS)) u_wall (
        .aclk(aclk), .we(wall_we), .waddr(wall_waddr), .wdata(wall_wdata),
        .raddr(map_raddr), .rdata(wall_rdata)
    );

    mbg_ram #(.DATA_W(1), .DEPTH(CELLS)) u_visited (
        .aclk(aclk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(map_raddr), .rdata(vis_rdata)
    );

    mbg_ram #(.DATA_W(AW), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    // Shared neighbour-address unit: cell one or two away in the current direction.
    // Each direction checks its own axis against the grid edge and the other axis
    // against the grid in use.
    logic          nb_step2;
    logic [XW+1:0] bx, nx;
    logic [YW+1:0] by, ny;
    logic [1:0]    st;
    logic          nb_ok;
    logic [AW-1:0] nb_addr;

    always_comb begin
        st = nb_step2 ? 2'd2 : 2'd1;
        bx = (XW+2)'(cx_reg);
        by = (YW+2)'(cy_reg);
        nx = bx;
        ny = by;
        nb_ok = 1'b0;
        case (dir_reg)
            DIR_PX: begin
                nx = bx + (XW+2)'(st);
                nb_ok = (nx < (XW+2)'(ew)) && (by < (YW+2)'(eh));
            end
            DIR_MX: begin
                nx = bx - (XW+2)'(st);
                nb_ok = (bx >= (XW+2)'(st)) && (by < (YW+2)'(eh));
            end
            DIR_PY: begin
                ny = by + (YW+2)'(st);
                nb_ok = (ny < (YW+2)'(eh)) && (bx < (XW+2)'(ew));
            end
            DIR_MY: begin
                ny = by - (YW+2)'(st);
                nb_ok = (by >= (YW+2)'(st)) && (bx < (XW+2)'(ew));
            end
            default: nb_ok = 1'b0;
        endcase
        nb_addr = {ny[YW-1:0], nx[XW-1:0]};
    end

    // Candidate pick: index choice mod count among the free directions
    logic [3:0] mask_now;
    logic [2:0] ncand;
    logic [1:0] kidx, cnt;
    logic       found;
    dir_t       pick;

    always_comb begin
        mask_now = mask_reg;
        if (ok_reg && !vis_rdata) begin
            mask_now[dir_reg] = 1'b1;
        end
        ncand = 3'($countones(mask_now));
        case (ncand)
            3'd2:    kidx = {1'b0, in_reg.choice[0]};
            3'd3:    kidx = mod3(in_reg.choice);
            3'd4:    kidx = in_reg.choice[1:0];
            default: kidx = 2'd0;
        endcase
        cnt = 2'd0;
        found = 1'b0;
        pick = DIR_PX;
        for (int i = 0; i < 4; i++) begin
            if (mask_now[i] && !found) begin
                if (cnt == kidx) begin
                    pick = dir_t'(2'(i));
                    found = 1'b1;
                end
                cnt = cnt + 2'd1;
            end
        end
    end

    // Raster residue steps for the current difficulty
    logic [2:0] rdiv, rxs, rys;
    assign rdiv = (difficulty_reg == DIFF_EASY) ? EASY_DIV_C : MED_DIV_C;
    assign rxs  = (difficulty_reg == DIFF_EASY) ? EASY_XSTEP : MED_XSTEP;
    assign rys  = (difficulty_reg == DIFF_EASY) ? EASY_YSTEP : MED_YSTEP;

    assign stk_raddr = SAW'(sc_reg - 1'b1);
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RST_CLR;
            sc_reg      <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sc_reg      <= sc_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        dir_reg    <= dir_next;
        mask_reg   <= mask_next;
        res_reg    <= res_next;
        rowres_reg <= rowres_next;
        ok_reg     <= ok_next;
        in_reg     <= in_next;
        rwall_reg  <= rwall_next;
        roor_reg   <= roor_next;
        m_data_reg <= m_data_next;
    end

    // Next state and datapath control
    always_comb begin
        state_next   = state_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        dir_next     = dir_reg;
        mask_next    = mask_reg;
        res_next     = res_reg;
        rowres_next  = rowres_reg;
        sc_next      = sc_reg;
        clr_next     = clr_reg;
        ok_next      = ok_reg;
        in_next      = in_reg;
        rwall_next   = rwall_reg;
        roor_next    = roor_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        nb_step2     = 1'b1;
        wall_we      = 1'b0;
        wall_waddr   = nb_addr;
        wall_wdata   = 1'b0;
        vis_we       = 1'b0;
        vis_waddr    = nb_addr;
        vis_wdata    = 1'b1;
        stk_we       = 1'b0;
        stk_waddr    = SAW'(sc_reg);
        stk_wdata    = nb_addr;
        map_raddr    = nb_addr;

        case (state_reg)
            // Sweep all cells to wall and unvisited
            ST_RST_CLR, ST_BEG_CLR: begin
                wall_we    = 1'b1;
                wall_waddr = clr_reg;
                wall_wdata = 1'b1;
                vis_we     = 1'b1;
                vis_waddr  = clr_reg;
                vis_wdata  = 1'b0;
                clr_next   = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = (state_reg == ST_RST_CLR) ? ST_IDLE : ST_BEG_SET;
                end
            end
            ST_IDLE: begin
                map_raddr = {YW'(s_data.cell_y), XW'(s_data.cell_x)};
                if (s_valid) begin
                    in_next    = s_data;
                    rwall_next = 1'b0;
                    roor_next  = 1'b0;
                    case (s_data.mode)
                        MODE_BEGIN: begin
                            clr_next   = '0;
                            state_next = ST_BEG_CLR;
                        end
                        MODE_WALK: begin
                            state_next = (sc_reg == '0) ? ST_RESP : ST_TOP;
                        end
                        MODE_FINISH: begin
                            state_next = ST_FIN_START;
                        end
                        default: begin
                            if (int'(s_data.cell_x) >= int'(ew) ||
                                int'(s_data.cell_y) >= int'(eh)) begin
                                rwall_next = 1'b1;
                                roor_next  = 1'b1;
                                state_next = ST_RESP;
                            end else begin
                                state_next = ST_READ;
                            end
                        end
                    endcase
                end
            end
            // Open, mark and push the start cell
            ST_BEG_SET: begin
                wall_we    = 1'b1;
                wall_waddr = {sy, sx};
                vis_we     = 1'b1;
                vis_waddr  = {sy, sx};
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = {sy, sx};
                sc_next    = CW'(1);
                state_next = ST_RESP;
            end
            // Take the top of stack
            ST_TOP: begin
                cx_next    = stk_rdata[XW-1:0];
                cy_next    = stk_rdata[AW-1:XW];
                dir_next   = DIR_PX;
                mask_next  = '0;
                state_next = ST_PROBE;
            end
            ST_PROBE: begin
                ok_next    = nb_ok;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                mask_next = mask_now;
                if (dir_reg == DIR_MY) begin
                    if (ncand == 3'd0) begin
                        sc_next    = sc_reg - 1'b1;
                        state_next = ST_RESP;
                    end else begin
                        dir_next   = pick;
                        state_next = ST_CARVE;
                    end
                end else begin
                    dir_next   = dir_t'(dir_reg + 2'd1);
                    state_next = ST_PROBE;
                end
            end
            // Open and mark the chosen cell, push it while there is room
            ST_CARVE: begin
                wall_we = 1'b1;
                vis_we  = 1'b1;
                if (int'(sc_reg) < STACK_DEPTH) begin
                    stk_we  = 1'b1;
                    sc_next = sc_reg + 1'b1;
                end
                state_next = ST_MID;
            end
            // Open the cell between
            ST_MID: begin
                nb_step2   = 1'b0;
                wall_we    = 1'b1;
                state_next = ST_RESP;
            end
            ST_FIN_START: begin
                wall_we    = 1'b1;
                wall_waddr = {sy, sx};
                state_next = ST_FIN_END;
            end
            ST_FIN_END: begin
                wall_we    = 1'b1;
                wall_waddr = {ey, ex};
                state_next = ST_FIN_LEFT;
            end
            ST_FIN_LEFT: begin
                wall_we    = (ex != '0);
                wall_waddr = {ey, XW'(ex - 1'b1)};
                state_next = ST_FIN_UP;
            end
            ST_FIN_UP: begin
                wall_we     = (ey != '0);
                wall_waddr  = {YW'(ey - 1'b1), ex};
                cx_next     = '0;
                cy_next     = '0;
                res_next    = '0;
                rowres_next = '0;
                state_next  = (difficulty_reg == DIFF_EASY || difficulty_reg == DIFF_MEDIUM)
                              ? ST_RAS_READ : ST_RESP;
            end
            ST_RAS_READ, ST_RAS_CHK, ST_RAS_PROBE, ST_RAS_EVAL: begin
                nb_step2 = 1'b0;
                ok_next  = 1'b0;
                // decide whether this cell is done
                case (state_reg)
                    ST_RAS_READ: begin
                        map_raddr = {cy_reg, cx_reg};
                        if (res_reg != '0) begin
                            ok_next = 1'b1;
                        end else begin
                            state_next = ST_RAS_CHK;
                        end
                    end
                    ST_RAS_CHK: begin
                        if (!wall_rdata) begin
                            ok_next = 1'b1;
                        end else begin
                            dir_next   = DIR_PX;
                            state_next = ST_RAS_PROBE;
                        end
                    end
                    ST_RAS_PROBE: begin
                        if (nb_ok) begin
                            state_next = ST_RAS_EVAL;
                        end else if (dir_reg == DIR_MY) begin
                            ok_next = 1'b1;
                        end else begin
                            dir_next = dir_t'(dir_reg + 2'd1);
                        end
                    end
                    default: begin
                        if (!wall_rdata) begin
                            wall_we    = 1'b1;
                            wall_waddr = {cy_reg, cx_reg};
                            ok_next    = 1'b1;
                        end else if (dir_reg == DIR_MY) begin
                            ok_next = 1'b1;
                        end else begin
                            dir_next   = dir_t'(dir_reg + 2'd1);
                            state_next = ST_RAS_PROBE;
                        end
                    end
                endcase
                // advance to the next cell in raster order
                if (ok_next) begin
                    if ((XW+1)'(cx_reg) + 1'b1 < ew) begin
                        cx_next    = cx_reg + 1'b1;
                        res_next   = res_add(res_reg, rxs, rdiv);
                        state_next = ST_RAS_READ;
                    end else if ((YW+1)'(cy_reg) + 1'b1 < eh) begin
                        cx_next     = '0;
                        cy_next     = cy_reg + 1'b1;
                        rowres_next = res_add(rowres_reg, rys, rdiv);
                        res_next    = res_add(rowres_reg, rys, rdiv);
                        state_next  = ST_RAS_READ;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_READ: begin
                rwall_next = wall_rdata;
                state_next = ST_RESP;
            end
            // Load the result once the output register is free
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.wall         = rwall_reg;
                    m_data_next.walk_done    = (sc_reg == '0);
                    m_data_next.out_of_range = roor_reg;
                    state_next               = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `MBG_ASSERT(a_sc_bound, aclk, aresetn, int'(sc_reg) <= STACK_DEPTH)
    `MBG_ASSERT(a_clr_busy, aclk, aresetn, (state_reg == ST_RST_CLR || state_reg == ST_BEG_CLR) |-> !s_ready)
    `MBG_ASSERT_NEXT(a_carve_mid, aclk, aresetn, state_reg == ST_CARVE, state_reg == ST_MID)
    `MBG_ASSERT_NEXT(a_resp_load, aclk, aresetn, state_reg == ST_RESP && (!m_valid_reg || m_ready), m_valid_reg)

endmodule

>>> sv/mbg_ram.sv
module mbg_ram #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

>>> verif/maze_backtracker_generator_tb.sv
`timescale 1ns / 100ps

module maze_backtracker_generator_tb;
    import mbg_pkg::*;

    localparam int GW = 64;
    localparam int GH = 64;
    localparam int SDEPTH = 1024;
    localparam int IDLE_LIMIT = 200000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [6:0] cfg_wdata = '0;

    maze_backtracker_generator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Mirror of the maze state and registers
    bit wall_mirror [GW*GH];
    bit seen_mirror [GW*GH];
    int path_stack [SDEPTH];
    int path_depth;
    int m_gw, m_gh, m_sx, m_sy, m_ex, m_ey, m_diff;

    out_t results_due [$];
    int mismatches;
    int idle_cycles;
    bit stall_pattern;

    function automatic int fit_size(int v, int mx);
        if (v == 0) return 1;
        return v > mx ? mx : v;
    endfunction

    function automatic int clip_pos(int v, int n);
        return v >= n ? n - 1 : v;
    endfunction

    function automatic bit any_open_side(int x, int y, int w, int h);
        if (x + 1 < w && !wall_mirror[y*GW + x + 1]) return 1;
        if (x > 0 && !wall_mirror[y*GW + x - 1]) return 1;
        if (y + 1 < h && !wall_mirror[(y+1)*GW + x]) return 1;
        if (y > 0 && !wall_mirror[(y-1)*GW + x]) return 1;
        return 0;
    endfunction

    function automatic void mirror_reset();
        for (int i = 0; i < GW*GH; i++) begin
            wall_mirror[i] = 1;
            seen_mirror[i] = 0;
        end
        path_depth = 0;
        m_gw = 64; m_gh = 64; m_sx = 0; m_sy = 0; m_ex = 63; m_ey = 63; m_diff = 2;
    endfunction

    function automatic void mirror_config(logic [2:0] ix, logic [6:0] v);
        case (ix)
            REG_GRID_WIDTH:  m_gw = v;
            REG_GRID_HEIGHT: m_gh = v;
            REG_START_X:     m_sx = v[5:0];
            REG_START_Y:     m_sy = v[5:0];
            REG_END_X:       m_ex = v[5:0];
            REG_END_Y:       m_ey = v[5:0];
            REG_DIFFICULTY:  m_diff = v[1:0];
            default: ;
        endcase
    endfunction

    // Work out the result of one request and advance the mirror
    function automatic out_t predict_maze(in_t r);
        int w, h, sx, sy, ex, ey, cx, cy, n, pick, dv, top;
        int cand [4];
        out_t o;
        w = fit_size(m_gw, GW);
        h = fit_size(m_gh, GH);
        sx = clip_pos(m_sx, w); sy = clip_pos(m_sy, h);
        ex = clip_pos(m_ex, w); ey = clip_pos(m_ey, h);
        o = '0;
        case (r.mode)
            MODE_BEGIN: begin
                for (int i = 0; i < GW*GH; i++) begin
                    wall_mirror[i] = 1;
                    seen_mirror[i] = 0;
                end
                wall_mirror[sy*GW + sx] = 0;
                seen_mirror[sy*GW + sx] = 1;
                path_stack[0] = sy*GW + sx;
                path_depth = 1;
            end
            MODE_WALK: begin
                if (path_depth != 0) begin
                    top = path_stack[path_depth - 1];
                    cx = top % GW;
                    cy = top / GW;
                    n = 0;
                    if (cx + 2 < w && cy < h && !seen_mirror[cy*GW + cx + 2]) begin
                        cand[n] = cy*GW + cx + 2; n++;
                    end
                    if (cx >= 2 && cy < h && !seen_mirror[cy*GW + cx - 2]) begin
                        cand[n] = cy*GW + cx - 2; n++;
                    end
                    if (cy + 2 < h && cx < w && !seen_mirror[(cy+2)*GW + cx]) begin
                        cand[n] = (cy+2)*GW + cx; n++;
                    end
                    if (cy >= 2 && cx < w && !seen_mirror[(cy-2)*GW + cx]) begin
                        cand[n] = (cy-2)*GW + cx; n++;
                    end
                    if (n == 0) begin
                        path_depth--;
                    end else begin
                        pick = cand[int'(r.choice) % n];
                        wall_mirror[((cy + pick/GW)/2)*GW + (cx + pick%GW)/2] = 0;
                        wall_mirror[pick] = 0;
                        seen_mirror[pick] = 1;
                        if (path_depth < SDEPTH) begin
                            path_stack[path_depth] = pick;
                            path_depth++;
                        end
                    end
                end
            end
            MODE_FINISH: begin
                wall_mirror[sy*GW + sx] = 0;
                wall_mirror[ey*GW + ex] = 0;
                if (ex > 0) wall_mirror[ey*GW + ex - 1] = 0;
                if (ey > 0) wall_mirror[(ey-1)*GW + ex] = 0;
                dv = (m_diff == DIFF_EASY) ? EASY_DIV : (m_diff == DIFF_MEDIUM) ? MED_DIV : 0;
                if (dv != 0) begin
                    for (int y = 0; y < h; y++) begin
                        for (int x = 0; x < w; x++) begin
                            if (wall_mirror[y*GW + x] && any_open_side(x, y, w, h) &&
                                (x*COEF_X + y*COEF_Y) % dv == 0)
                                wall_mirror[y*GW + x] = 0;
                        end
                    end
                end
            end
            default: begin
                if (r.cell_x >= w || r.cell_y >= h) begin
                    o.out_of_range = 1;
                    o.wall = 1;
                end else begin
                    o.wall = wall_mirror[int'(r.cell_y)*GW + r.cell_x];
                end
            end
        endcase
        o.walk_done = (path_depth == 0);
        return o;
    endfunction

    // Check results at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result wall=%0b done=%0b oor=%0b",
                             m_data.wall, m_data.walk_done, m_data.out_of_range);
            end else begin
                out_t want;
                want = results_due.pop_front();
                if (want !== m_data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected w/d/o %0b%0b%0b got %0b%0b%0b",
                                 want.wall, want.walk_done, want.out_of_range,
                                 m_data.wall, m_data.walk_done, m_data.out_of_range);
                end
            end
        end
    end

    // Watchdog on accept activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("maze_backtracker_generator_tb: done, errors");
            $finish;
        end
    end

    // Receiver stalls in its own pattern
    always @(negedge aclk) begin
        if (!stall_pattern)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(0, 3) != 0);
    end

    always begin
        repeat ($urandom_range(50, 400)) @(negedge aclk);
        stall_pattern = ~stall_pattern;
    end

    // Present one request and wait for its acceptance; valid stays high for a following one
    task automatic send_request(in_t r, bit typed, out_t typed_out);
        out_t want;
        want = predict_maze(r);
        if (typed && typed_out !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table disagrees with predictor for mode %0d", r.mode);
        end
        results_due = {results_due, want};
        s_data <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write enable stays high for a following write
    task automatic write_reg(logic [2:0] ix, logic [6:0] v);
        cfg_index <= ix;
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge aclk);
        mirror_config(ix, v);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic in_t make_req(logic [1:0] md, logic [15:0] ch, logic [5:0] x,
                                     logic [5:0] y);
        in_t r;
        r.mode = md; r.choice = ch; r.cell_x = x; r.cell_y = y;
        return r;
    endfunction

    typedef struct {
        logic [1:0] md;
        logic [15:0] ch;
        logic [5:0] x;
        logic [5:0] y;
        bit typed;
        logic [2:0] want;
    } step_row_t;

    // Directed table: expected bits wall, walk_done, out_of_range
    step_row_t directed [] = '{
        '{MODE_READ,   16'h0000, 6'd0,  6'd0,  1, 3'b110},
        '{MODE_WALK,   16'hFFFF, 6'd0,  6'd0,  1, 3'b010},
        '{MODE_READ,   16'h0000, 6'd63, 6'd63, 1, 3'b110},
        '{MODE_BEGIN,  16'h0000, 6'd0,  6'd0,  1, 3'b000},
        '{MODE_READ,   16'h0000, 6'd0,  6'd0,  1, 3'b000},
        '{MODE_READ,   16'h0000, 6'd1,  6'd0,  1, 3'b100},
        '{MODE_WALK,   16'h0000, 6'd0,  6'd0,  0, 3'b000},
        '{MODE_WALK,   16'hFFFF, 6'd0,  6'd0,  0, 3'b000},
        '{MODE_WALK,   16'h5555, 6'd0,  6'd0,  0, 3'b000},
        '{MODE_READ,   16'h0000, 6'd2,  6'd0,  0, 3'b000},
        '{MODE_READ,   16'h0000, 6'd0,  6'd2,  0, 3'b000},
        '{MODE_FINISH, 16'h0000, 6'd0,  6'd0,  0, 3'b000},
        '{MODE_READ,   16'h0000, 6'd63, 6'd63, 0, 3'b000},
        '{MODE_READ,   16'h0000, 6'd62, 6'd63, 0, 3'b000}
    };

    task automatic run_random(int count, int deep);
        int burst;
        in_t r;
        for (int i = 0; i < count;) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && i < count; k++, i++) begin
                r.choice = $urandom_range(0, 65535);
                r.cell_x = $urandom_range(0, 63);
                r.cell_y = $urandom_range(0, 63);
                case ($urandom_range(0, 99))
                    0, 1: r.mode = MODE_BEGIN;
                    2:    r.mode = deep ? MODE_FINISH : MODE_READ;
                    default: r.mode = ($urandom_range(0, 2) != 0) ? MODE_WALK : MODE_READ;
                endcase
                send_request(r, 0, '0);
            end
            // drop valid for a gap between bursts
            if ($urandom_range(0, 2) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
        end
    endtask

    task automatic set_grid(int w, int h, int sx, int sy, int ex, int ey, int df);
        write_reg(REG_GRID_WIDTH, 7'(w));
        write_reg(REG_GRID_HEIGHT, 7'(h));
        write_reg(REG_START_X, 7'(sx));
        write_reg(REG_START_Y, 7'(sy));
        write_reg(REG_END_X, 7'(ex));
        write_reg(REG_END_Y, 7'(ey));
        write_reg(REG_DIFFICULTY, 7'(df));
        write_reg(3'd7, 7'h7F);
        cfg_we <= 1'b0;
    endtask

    initial begin
        out_t tw;
        mismatches = 0;
        idle_cycles = 0;
        stall_pattern = 0;
        mirror_reset();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Walk the directed table at reset settings
        foreach (directed[i]) begin
            tw = directed[i].want;
            send_request(make_req(directed[i].md, directed[i].ch, directed[i].x, directed[i].y),
                         directed[i].typed, tw);
        end
        drain();

        // Sweep settings: zero and oversized grids, clipped start/end, every difficulty
        set_grid(0, 0, 63, 63, 63, 63, 0);
        run_random(20, 1);
        drain();
        set_grid(127, 127, 5, 7, 0, 0, 1);
        run_random(60, 1);
        drain();
        set_grid(9, 7, 63, 2, 3, 63, 3);
        run_random(200, 1);
        drain();
        set_grid(13, 11, 4, 6, 12, 10, 0);
        run_random(250, 1);
        drain();
        set_grid(21, 64, 20, 0, 0, 63, 1);
        run_random(200, 1);
        drain();
        set_grid(64, 1, 0, 0, 63, 0, 2);
        run_random(70, 0);
        drain();

        if (mismatches == 0 && results_due.size() == 0) begin
            $display("maze_backtracker_generator_tb: done, clean");
        end else begin
            $display("maze_backtracker_generator_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/mbg_pkg.sv
sv/mbg_ram.sv
sv/maze_backtracker_generator.sv
verif/maze_backtracker_generator_tb.sv
